/* hdl/command_frame_encoder_crc32_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the command frame encoder
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_ENCODER_CRC32_MACROS_SVH
`define COMMAND_FRAME_ENCODER_CRC32_MACROS_SVH

// Same-cycle implication
`define CFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame encoder assertion failed");

// Next-cycle implication
`define CFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame encoder assertion failed");

`endif

/* hdl/cfe_pkg.sv */
// ----------------------------------------------------------------------------
// Command frame encoder package
// Beat types, byte positions within a frame, register indexes and CRC-32.
// ----------------------------------------------------------------------------
package cfe_pkg;

  // Zero bytes ahead of the head byte
  localparam int unsigned PREAMBLE_LEN = 8;

  // Byte positions within one frame
  localparam int unsigned POS_COUNT = PREAMBLE_LEN + 9;
  localparam int unsigned POS_W     = $clog2(POS_COUNT);

  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HEAD  = POS_W'(PREAMBLE_LEN);
  localparam logic [POS_W-1:0] POS_CMD   = POS_W'(PREAMBLE_LEN + 1);
  localparam logic [POS_W-1:0] POS_LEN   = POS_W'(PREAMBLE_LEN + 2);
  localparam logic [POS_W-1:0] POS_DATA  = POS_W'(PREAMBLE_LEN + 3);
  localparam logic [POS_W-1:0] POS_TAIL  = POS_W'(PREAMBLE_LEN + 4);
  localparam logic [POS_W-1:0] POS_CRC0  = POS_W'(PREAMBLE_LEN + 5);
  localparam logic [POS_W-1:0] POS_CRC1  = POS_W'(PREAMBLE_LEN + 6);
  localparam logic [POS_W-1:0] POS_CRC2  = POS_W'(PREAMBLE_LEN + 7);
  localparam logic [POS_W-1:0] POS_CRC3  = POS_W'(PREAMBLE_LEN + 8);

  // Configuration register indexes and reset values
  localparam logic       CFG_HEAD   = 1'b0;
  localparam logic       CFG_TAIL   = 1'b1;
  localparam logic [7:0] HEAD_RESET = 8'h0A;
  localparam logic [7:0] TAIL_RESET = 8'h0B;

  // CRC-32, reflected
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

  typedef struct packed {
    logic       start_req;
    logic [7:0] command_code;
    logic [7:0] payload_count;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_beat_t;

  // Byte run produced by one accepted item
  typedef struct packed {
    logic        start;
    logic [7:0]  cmd;
    logic [7:0]  len_byte;
    logic        has_data;
    logic [7:0]  data;
    logic        finish;
    logic [31:0] crc_out;
  } run_desc_t;

  typedef struct packed {
    logic busy;
    logic last_adv;
  } ser_status_t;

  typedef struct packed {
    logic open;
    logic left_zero;
  } frame_status_t;

  // Constant 256-entry table of the byte-wise reflected CRC
  function automatic logic [31:0] crc_table(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [7:0] idx;
    idx = crc[7:0] ^ b;
    return (crc >> 8) ^ crc_table(idx);
  endfunction

endpackage

/* hdl/cfe_frame.sv */
// ----------------------------------------------------------------------------
// Frame state and CRC update
// Tracks the open frame, folds each item that opens or feeds a frame into the
// running CRC and describes the byte run that the item causes.
// ----------------------------------------------------------------------------
module cfe_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  acc_i,
  input  cfe_pkg::in_item_t     item_i,
  output logic                  desc_valid_o,
  output cfe_pkg::run_desc_t    desc_o,
  output cfe_pkg::frame_status_t status_o
);

  logic        open_q, open_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] crc_q, crc_d;

  logic [7:0]  len_byte;
  logic [31:0] crc_hdr, crc_base, crc_pay, crc_end;
  logic [7:0]  left_base, left_after;
  logic        has_data, finish;

  // Work out the CRC and byte count for this item
  always_comb begin
    len_byte   = item_i.payload_count + 8'd1;
    crc_hdr    = cfe_pkg::crc_byte(cfe_pkg::crc_byte(32'd0, item_i.command_code), len_byte);
    crc_base   = item_i.start_req ? crc_hdr : crc_q;
    crc_pay    = cfe_pkg::crc_byte(crc_base, item_i.data_byte);
    left_base  = item_i.start_req ? item_i.payload_count : left_q;
    has_data   = item_i.start_req ? (item_i.payload_count != 8'd0) : 1'b1;
    left_after = left_base - 8'd1;
    finish     = has_data ? (left_after == 8'd0) : 1'b1;
    crc_end    = has_data ? crc_pay : crc_base;
  end

  // Payload with no frame open causes nothing
  assign desc_valid_o = acc_i && (item_i.start_req || open_q);

  always_comb begin
    desc_o.start    = item_i.start_req;
    desc_o.cmd      = item_i.command_code;
    desc_o.len_byte = len_byte;
    desc_o.has_data = has_data;
    desc_o.data     = item_i.data_byte;
    desc_o.finish   = finish;
    desc_o.crc_out  = crc_end ^ cfe_pkg::CRC_XOROUT;
  end

  // Advance frame state on each item that opens or feeds a frame
  always_comb begin
    open_d = open_q;
    left_d = left_q;
    crc_d  = crc_q;
    if (desc_valid_o) begin
      open_d = !finish;
      left_d = finish ? 8'd0 : left_after;
      crc_d  = crc_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
      crc_q  <= 32'd0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
      crc_q  <= crc_d;
    end
  end

  assign status_o.open      = open_q;
  assign status_o.left_zero = (left_q == 8'd0);

endmodule

/* hdl/cfe_ser.sv */
// ----------------------------------------------------------------------------
// Frame byte serialiser
// Holds one byte run and moves it out a byte per cycle while the output is not
// stalled, through a registered output stage with valid and ready.
// ----------------------------------------------------------------------------
module cfe_ser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  cfe_pkg::run_desc_t        desc_i,
  input  logic [7:0]                head_byte_i,
  input  logic [7:0]                tail_byte_i,
  output logic                      in_ready_o,
  output cfe_pkg::ser_status_t      status_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cfe_pkg::out_beat_t        out_beat_o
);

  cfe_pkg::run_desc_t         desc_q;
  logic                       busy_q, busy_d;
  logic [cfe_pkg::POS_W-1:0]  pos_q, pos_d, pos_next;
  logic                       ov_q, ov_d;
  cfe_pkg::out_beat_t         beat_q, beat_d;

  logic       adv, is_last;
  logic [7:0] cur_byte;

  // Move a byte when the output stage is free or being taken
  assign adv     = busy_q && (!ov_q || out_ready_i);
  assign is_last = (pos_q == cfe_pkg::POS_CRC3) ||
                   ((pos_q == cfe_pkg::POS_DATA) && !desc_q.finish);
  assign in_ready_o = !busy_q || (adv && is_last);

  // Pick the byte at the current position
  always_comb begin
    if (pos_q < cfe_pkg::POS_HEAD) begin
      cur_byte = 8'd0;
    end else begin
      unique case (pos_q)
        cfe_pkg::POS_HEAD: cur_byte = head_byte_i;
        cfe_pkg::POS_CMD:  cur_byte = desc_q.cmd;
        cfe_pkg::POS_LEN:  cur_byte = desc_q.len_byte;
        cfe_pkg::POS_DATA: cur_byte = desc_q.data;
        cfe_pkg::POS_TAIL: cur_byte = tail_byte_i;
        cfe_pkg::POS_CRC0: cur_byte = desc_q.crc_out[7:0];
        cfe_pkg::POS_CRC1: cur_byte = desc_q.crc_out[15:8];
        cfe_pkg::POS_CRC2: cur_byte = desc_q.crc_out[23:16];
        cfe_pkg::POS_CRC3: cur_byte = desc_q.crc_out[31:24];
        default:           cur_byte = 8'd0;
      endcase
    end
  end

  // Skip the data byte of an empty frame
  assign pos_next = ((pos_q == cfe_pkg::POS_LEN) && !desc_q.has_data) ?
                    cfe_pkg::POS_TAIL : pos_q + cfe_pkg::POS_W'(1);

  // Run control
  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (load_i) begin
      busy_d = 1'b1;
      pos_d  = desc_i.start ? cfe_pkg::POS_FIRST : cfe_pkg::POS_DATA;
    end else if (adv && is_last) begin
      busy_d = 1'b0;
    end else if (adv) begin
      pos_d = pos_next;
    end
  end

  // Output stage
  always_comb begin
    ov_d   = ov_q;
    beat_d = beat_q;
    if (adv) begin
      ov_d             = 1'b1;
      beat_d.out_byte  = cur_byte;
      beat_d.frame_end = (pos_q == cfe_pkg::POS_CRC3);
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= cfe_pkg::POS_FIRST;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      ov_q   <= ov_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

  assign out_valid_o       = ov_q;
  assign out_beat_o        = beat_q;
  assign status_o.busy     = busy_q;
  assign status_o.last_adv = adv && is_last;

endmodule

/* hdl/command_frame_encoder_crc32.sv */
// ----------------------------------------------------------------------------
// Command frame encoder with CRC-32
// Turns start and payload items into framed command bytes.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_item_i): a start beat opens a frame
// and gives command, payload count and first payload byte; payload beats give
// the following bytes. A payload beat with no frame open is dropped.
// Output channel (out_valid_o/out_ready_i, out_beat_o): one frame byte per
// beat; frame_end marks the last CRC byte.
// Config port (cfg_we_i, cfg_idx_i, cfg_wdata_i): head and tail marker bytes;
// the user writes them only while the block is idle; the block does not check.
// On acceptance an item is loaded into the serialiser's run registers, and its
// first byte moves from there into the output register.
// Throughput: one output byte per cycle while the receiver takes them, set by
// the byte serialiser. A payload beat yields 1 byte, 6 when it closes the frame;
// a start beat yields PREAMBLE_LEN + 4 bytes, PREAMBLE_LEN + 8 with no payload,
// or PREAMBLE_LEN + 9 when its one payload byte closes the frame.
// The next item is taken in the cycle the last byte of the current one moves.
// Receiver stall: the output register holds, the serialiser and then the
// input channel stall with it; nothing is lost.
// Reset: no frame open, CRC cleared, head 0x0A and tail 0x0B.
// ----------------------------------------------------------------------------
`include "command_frame_encoder_crc32_macros.svh"

module command_frame_encoder_crc32 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cfe_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfe_pkg::out_beat_t out_beat_o
);

  logic [7:0] head_q, tail_q;

  logic                   in_acc;
  logic                   desc_valid;
  cfe_pkg::run_desc_t     desc;
  cfe_pkg::ser_status_t   ser_st;
  cfe_pkg::frame_status_t frm_st;

  // Marker byte registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= cfe_pkg::HEAD_RESET;
      tail_q <= cfe_pkg::TAIL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfe_pkg::CFG_HEAD: head_q <= cfg_wdata_i;
        cfe_pkg::CFG_TAIL: tail_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid_i && in_ready_o;

  cfe_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .item_i       (in_item_i),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .status_o     (frm_st)
  );

  cfe_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (desc_valid),
    .desc_i      (desc),
    .head_byte_i (head_q),
    .tail_byte_i (tail_q),
    .in_ready_o  (in_ready_o),
    .status_o    (ser_st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // A new byte run never overwrites one still being sent
  `CFE_ASSERT_IMPL(a_load_free, desc_valid, !ser_st.busy || ser_st.last_adv)
  // An open frame always expects at least one more payload byte
  `CFE_ASSERT_IMPL(a_open_left, frm_st.open, !frm_st.left_zero)
  // Output data only ever comes from a busy serialiser
  `CFE_ASSERT_NEXT(a_out_src, !out_valid_o && !ser_st.busy, !out_valid_o)

endmodule

/* tb/command_frame_encoder_crc32_tb.sv */
// ----------------------------------------------------------------------------
// Command frame encoder testbench
// Drives start and payload beats through the valid/ready input channel and
// checks every frame byte against a local model of the framing and CRC-32.
// Covers head and tail marker settings and random idling on both channels.
// It also covers a long receiver stall and drops of open frames.
// ----------------------------------------------------------------------------
module command_frame_encoder_crc32_tb;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_idx_i   = 1'b0;
  logic [7:0]         cfg_wdata_i = 8'h00;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  cfe_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  cfe_pkg::out_beat_t out_beat_o;

  command_frame_encoder_crc32 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // Beats waiting to be offered and frame bytes still owed by the block
  cfe_pkg::in_item_t  pending_q[$];
  cfe_pkg::out_beat_t frame_bytes_q[$];
  cfe_pkg::out_beat_t want_beat;

  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;
  logic recv_hold      = 1'b0;
  logic in_fire        = 1'b0;

  // Local copy of the framer state and marker registers
  logic       frm_open  = 1'b0;
  logic [7:0] frm_left  = 8'h00;
  logic [31:0] frm_crc  = 32'h0;
  logic [7:0] head_mark = cfe_pkg::HEAD_RESET;
  logic [7:0] tail_mark = cfe_pkg::TAIL_RESET;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // End the run if it hangs
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Reflected CRC-32, one bit per pass
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ cfe_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void owe_byte(input logic [7:0] b, input logic last);
    cfe_pkg::out_beat_t bt;
    bt.out_byte  = b;
    bt.frame_end = last;
    frame_bytes_q.push_back(bt);
  endfunction

  // Close the frame: tail marker then the CRC, low byte first
  function automatic void close_frame();
    logic [31:0] c;
    c = frm_crc ^ cfe_pkg::CRC_XOROUT;
    owe_byte(tail_mark, 1'b0);
    owe_byte(c[7:0], 1'b0);
    owe_byte(c[15:8], 1'b0);
    owe_byte(c[23:16], 1'b0);
    owe_byte(c[31:24], 1'b1);
    frm_open = 1'b0;
    frm_left = 8'h00;
  endfunction

  function automatic void take_payload(input logic [7:0] b);
    frm_crc = crc32_step(frm_crc, b);
    owe_byte(b, 1'b0);
    frm_left = frm_left - 8'd1;
    if (frm_left == 8'd0) close_frame();
  endfunction

  // Work out the frame bytes one accepted beat causes
  function automatic void predict_frame_bytes(input cfe_pkg::in_item_t it);
    logic [7:0] len_b;
    if (it.start_req) begin
      len_b = it.payload_count + 8'd1;
      for (int i = 0; i < cfe_pkg::PREAMBLE_LEN; i++) owe_byte(8'h00, 1'b0);
      owe_byte(head_mark, 1'b0);
      owe_byte(it.command_code, 1'b0);
      owe_byte(len_b, 1'b0);
      frm_crc  = crc32_step(crc32_step(32'h0, it.command_code), len_b);
      frm_left = it.payload_count;
      frm_open = 1'b1;
      if (it.payload_count == 8'd0) close_frame();
      else take_payload(it.data_byte);
    end else if (frm_open) begin
      take_payload(it.data_byte);
    end
  endfunction

  // Offer the next pending beat once the current one is taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (rst_ni && pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i  <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a held-off stretch
  always @(negedge clk_i) begin
    if (recv_hold) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on accepted input beats, check every output beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) predict_frame_bytes(in_item_i);
      if (out_valid_o && out_ready_i) begin
        if (frame_bytes_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected beat, expected none, got byte %02h end %0b",
                   $time, out_beat_o.out_byte, out_beat_o.frame_end);
        end else begin
          want_beat = frame_bytes_q.pop_front();
          if (out_beat_o.out_byte !== want_beat.out_byte) begin
            mismatch_count++;
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want_beat.out_byte, out_beat_o.out_byte);
          end
          if (out_beat_o.frame_end !== want_beat.frame_end) begin
            mismatch_count++;
            $display("%0t: frame_end mismatch, expected %0b, got %0b",
                     $time, want_beat.frame_end, out_beat_o.frame_end);
          end
        end
      end
    end
  end

  task automatic push_item(input logic st, input logic [7:0] cmd, input logic [7:0] cnt,
                           input logic [7:0] data);
    cfe_pkg::in_item_t it;
    it.start_req     = st;
    it.command_code  = cmd;
    it.payload_count = cnt;
    it.data_byte     = data;
    pending_q.push_back(it);
  endtask

  // Start beat plus payload beats, beats in all; fewer than the count cuts it short
  task automatic push_frame(input logic [7:0] cmd, input int cnt, input int beats);
    push_item(1'b1, cmd, 8'(cnt), 8'($urandom));
    for (int i = 1; i < beats; i++) begin
      push_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Mostly whole frames of small size, some cut short, some stray payload beats
  task automatic gen_frames(input int n);
    int got;
    int pick;
    int cnt;
    int beats;
    got = 0;
    while (got < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        got++;
      end else begin
        cnt   = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 0);
        beats = (cnt == 0) ? 1 : cnt;
        if (pick < 18 && cnt >= 2) beats = $urandom_range(cnt - 1, 1);
        push_frame(8'($urandom), cnt, beats);
        got += beats;
      end
    end
  endtask

  task automatic set_marker(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == cfe_pkg::CFG_HEAD) head_mark = val;
    else tail_mark = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every beat is taken and every frame byte has come, then settle
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || frame_bytes_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats at the reset markers
    @(posedge clk_i);
    send_idle_pct = 16;
    recv_idle_pct = 45;
    push_item(1'b0, 8'hFF, 8'hFF, 8'hFF);        // payload with nothing open
    push_item(1'b1, 8'h00, 8'd0, 8'hFF);         // zero payload, data ignored
    push_item(1'b1, 8'hFF, 8'd1, 8'h00);         // single payload byte
    push_frame(8'hA5, 3, 3);
    push_item(1'b0, 8'h00, 8'h00, 8'h77);        // stray beat after close
    push_frame(8'h3C, 4, 2);                     // dropped by the next start
    push_frame(8'hC3, 2, 2);
    push_frame(8'h81, 255, 2);                   // length byte wraps to zero
    push_frame(8'h7E, 254, 2);                   // largest count whose length byte does not wrap, dropped
    push_item(1'b1, 8'h12, 8'd0, 8'h34);
    push_frame(8'h55, 5, 5);
    drain();

    // Extreme markers, sender idles lightly and receiver heavily
    set_marker(cfe_pkg::CFG_HEAD, 8'h00);
    set_marker(cfe_pkg::CFG_TAIL, 8'hFF);
    @(posedge clk_i);
    gen_frames(100);
    drain();

    // Opposite extremes, roles swapped, with one long receiver stall
    set_marker(cfe_pkg::CFG_HEAD, 8'hFF);
    set_marker(cfe_pkg::CFG_TAIL, 8'h00);
    @(posedge clk_i);
    send_idle_pct = 45;
    recv_idle_pct = 16;
    gen_frames(60);
    recv_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    recv_hold = 1'b0;
    drain();

    // Random markers, no idling, one full frame with the wrapped count
    set_marker(cfe_pkg::CFG_HEAD, 8'($urandom));
    set_marker(cfe_pkg::CFG_TAIL, 8'($urandom));
    @(posedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_frames(20);
    push_frame(8'($urandom), 255, 255);
    gen_frames(20);
    drain();

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/cfe_pkg.sv
hdl/cfe_frame.sv
hdl/cfe_ser.sv
hdl/command_frame_encoder_crc32.sv
tb/command_frame_encoder_crc32_tb.sv
